FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge; reset (active low) disables it.
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Assert that a stalled signal keeps its value into the next cycle.
`define CHK_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) vld && !rdy |=> $stable(sig)) \
    else $error("stalled item changed");

`endif

FILE: rtl/lsfc_pkg.sv
// Shared constants and types of the lane segment fit and center block.
package lsfc_pkg;

  localparam int REG_W          = 11;
  localparam int X_W            = 16;
  localparam int QB             = X_W - 1;
  localparam int CASE_W         = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int OUT_DATA_W     = 80;
  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_BITS_DEF = 11;
  localparam int MISSING_OFFSET = 9999;

  typedef logic [REG_W-1:0]     reg_val_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CASE_W-1:0]    case_t;

  localparam reg_val_t IMAGE_WIDTH_RST = 11'd900;
  localparam reg_val_t BOTTOM_ROW_RST  = 11'd600;
  localparam reg_val_t TOP_ROW_RST     = 11'd360;
  localparam reg_val_t STEER_WIDTH_RST = 11'd900;

  localparam cfg_idx_t CFG_IMAGE_WIDTH = 2'd0;
  localparam cfg_idx_t CFG_BOTTOM_ROW  = 2'd1;
  localparam cfg_idx_t CFG_TOP_ROW     = 2'd2;
  localparam cfg_idx_t CFG_STEER_WIDTH = 2'd3;

  localparam case_t CASE_BOTH  = 2'd0;
  localparam case_t CASE_RIGHT = 2'd1;
  localparam case_t CASE_LEFT  = 2'd2;
  localparam case_t CASE_HELD  = 2'd3;

endpackage

FILE: rtl/lane_segment_fit_center_core.sv
// Lane segment fit and steering center: accumulation, serial fit, center pick.
//
// Segments stream in one item at a time. A dropped segment, or one that lands
// in no lane, keeps the block idle; a segment added to a lane holds the input
// while the bit-serial multiplier forms its squared and cross terms one
// multiplier bit per cycle. The item that ends a frame starts the fit: per
// lane 6 + 2*2 serial products of OP_W = 2*clog2(MAX_POINTS+1) + 2*COORD_BITS
// + 1 bits and 2 restoring divisions, then the center pick. The input accepts
// items only while no segment or fit is in work; a finished result waits in
// the output register without blocking it.
// Configuration writes are always accepted and should arrive while idle.
module lane_segment_fit_center_core import lsfc_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_DATA_W = ((4 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // x_start, y_start, x_end, y_end, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // segment_valid
  input  logic                  in_tuser,
  // frame_last
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // center_x, left_x_low, left_x_high, right_x_high, right_x_low, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // center_case
  output logic [CASE_W-1:0]     out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_data
);

  localparam int CB    = COORD_BITS;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SX_W  = CNT_W + CB;
  localparam int SXX_W = CNT_W + 2 * CB;
  localparam int OP_W  = 2 * CNT_W + 2 * CB + 1;
  localparam int PW    = 2 * OP_W;
  localparam int DV_W  = PW + QB;
  localparam int LEN_W = $clog2(OP_W + 1);
  localparam int CMP_W = (CB + 1 > REG_W) ? CB + 1 : REG_W;
  localparam int XC_W  = X_W + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEG  = 3'd1;
  localparam logic [2:0] ST_FIT  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_CTR  = 3'd4;

  localparam logic [2:0] SS_X1X1 = 3'd0;
  localparam logic [2:0] SS_X2X2 = 3'd1;
  localparam logic [2:0] SS_X1Y1 = 3'd2;
  localparam logic [2:0] SS_X2Y2 = 3'd3;

  localparam logic [2:0] FS_NXX = 3'd0;
  localparam logic [2:0] FS_SXX = 3'd1;
  localparam logic [2:0] FS_NXY = 3'd2;
  localparam logic [2:0] FS_SXY = 3'd3;
  localparam logic [2:0] FS_SN  = 3'd4;
  localparam logic [2:0] FS_NN  = 3'd5;
  localparam logic [2:0] FS_NY  = 3'd6;
  localparam logic [2:0] FS_TD  = 3'd7;

  // configuration
  reg_val_t img_w_r, bot_r, top_r, stw_r;

  // per-lane sums, index 0 left, 1 right
  logic [CNT_W-1:0] cnt_r [2];
  logic [SX_W-1:0]  sx_r  [2];
  logic [SX_W-1:0]  sy_r  [2];
  logic [SXX_W-1:0] sxx_r [2];
  logic [SXX_W-1:0] sxy_r [2];

  logic [2:0]       state_r, step_r;
  logic             mbusy_r, lane_r, row_r, side_r, last_r, has_seg_r;
  reg_val_t         prev_r;
  logic [CB-1:0]    x1_r, y1_r, x2_r, y2_r;

  // serial multiplier
  logic [PW-1:0]    ma_r, acc_r;
  logic [OP_W-1:0]  mb_r;
  logic             mneg_r;
  logic [LEN_W-1:0] mcnt_r;

  // fit terms
  logic signed [OP_W-1:0] t_r, d_r, nn_r;
  logic signed [PW-1:0]   s_r, den_r;

  // divider
  logic [PW-1:0]    rem_r;
  logic [DV_W-1:0]  dd_r;
  logic [QB-1:0]    q_r;
  logic             dneg_r, dchk_r;
  logic [3:0]       dcnt_r;

  logic signed [X_W-1:0] xr_r [4];

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  case_t                 out_user_r;

  // input decode
  logic [CB-1:0]    in_x1, in_y1, in_x2, in_y2, adx, ady;
  logic             keep, pos, go_right, go_left, sel, room, add_seg, accept;
  logic [CMP_W-1:0] dx1, dx2, wd;
  logic [CNT_W:0]   cnt_plus2;

  // multiplier operands
  logic signed [OP_W-1:0] op_a, op_b, a_mag, b_mag;
  logic [LEN_W-1:0]       op_len;
  logic signed [PW-1:0]   prod;
  logic signed [OP_W-1:0] ext_n, ext_sx, ext_sy, ext_sxx, ext_sxy, ext_row;
  logic signed [OP_W-1:0] ext_x1, ext_x2, ext_y1, ext_y2, nn_new;
  logic signed [PW-1:0]   num_new, num_mag, den_mag;

  // divider step and result
  logic                  ge;
  logic [QB-1:0]         q_fin;
  logic signed [X_W-1:0] div_x;

  // center pick
  logic signed [X_W-1:0]  lb, lt, rb, rt, llo, lhi, rhi, rlo;
  logic signed [XC_W-1:0] wv, csum;
  logic                   left_in, right_in;
  reg_val_t               center;
  case_t                  ccase;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign in_x1 = in_tdata[CB-1:0];
  assign in_y1 = in_tdata[2*CB-1:CB];
  assign in_x2 = in_tdata[3*CB-1:2*CB];
  assign in_y2 = in_tdata[4*CB-1:3*CB];

  always_comb begin
    adx  = (in_x2 > in_x1) ? in_x2 - in_x1 : in_x1 - in_x2;
    ady  = (in_y2 > in_y1) ? in_y2 - in_y1 : in_y1 - in_y2;
    keep = (in_x2 == in_x1) || ({ady, 1'b0} > {1'b0, adx});
    pos  = (in_x2 == in_x1) || ((in_y2 > in_y1) == (in_x2 > in_x1));
    dx1  = CMP_W'({in_x1, 1'b0});
    dx2  = CMP_W'({in_x2, 1'b0});
    wd   = CMP_W'(img_w_r);
    go_right = keep && pos && (dx1 > wd) && (dx2 > wd);
    go_left  = keep && !pos && (dx1 < wd) && (dx2 < wd);
  end

  // one read port into the lane sums
  always_comb begin
    case (state_r)
      ST_IDLE: sel = go_right;
      ST_SEG:  sel = side_r;
      default: sel = lane_r;
    endcase
  end

  assign cnt_plus2 = {1'b0, cnt_r[sel]} + (CNT_W + 1)'(2);
  assign room      = (cnt_plus2 <= (CNT_W + 1)'(MAX_POINTS));
  assign add_seg   = in_tuser && (go_right || go_left) && room;

  assign ext_n   = $signed({{(OP_W - CNT_W){1'b0}}, cnt_r[sel]});
  assign ext_sx  = $signed({{(OP_W - SX_W){1'b0}}, sx_r[sel]});
  assign ext_sy  = $signed({{(OP_W - SX_W){1'b0}}, sy_r[sel]});
  assign ext_sxx = $signed({{(OP_W - SXX_W){1'b0}}, sxx_r[sel]});
  assign ext_sxy = $signed({{(OP_W - SXX_W){1'b0}}, sxy_r[sel]});
  assign ext_row = $signed({{(OP_W - REG_W){1'b0}}, (row_r ? top_r : bot_r)});
  assign ext_x1  = $signed({{(OP_W - CB){1'b0}}, x1_r});
  assign ext_x2  = $signed({{(OP_W - CB){1'b0}}, x2_r});
  assign ext_y1  = $signed({{(OP_W - CB){1'b0}}, y1_r});
  assign ext_y2  = $signed({{(OP_W - CB){1'b0}}, y2_r});

  always_comb begin
    op_a   = ext_n;
    op_b   = ext_sxx;
    op_len = LEN_W'(OP_W);
    if (state_r == ST_SEG) begin
      op_len = LEN_W'(CB);
      case (step_r)
        SS_X1X1: begin op_a = ext_x1; op_b = ext_x1; end
        SS_X2X2: begin op_a = ext_x2; op_b = ext_x2; end
        SS_X1Y1: begin op_a = ext_x1; op_b = ext_y1; end
        default: begin op_a = ext_x2; op_b = ext_y2; end
      endcase
    end else begin
      case (step_r)
        FS_NXX:  begin op_a = ext_n;  op_b = ext_sxx; end
        FS_SXX:  begin op_a = ext_sx; op_b = ext_sx;  end
        FS_NXY:  begin op_a = ext_n;  op_b = ext_sxy; end
        FS_SXY:  begin op_a = ext_sx; op_b = ext_sy;  end
        FS_SN:   begin op_a = ext_sx; op_b = nn_r;    end
        FS_NN:   begin op_a = ext_n;  op_b = nn_r;    end
        FS_NY:   begin op_a = ext_n;  op_b = ext_row; end
        default: begin op_a = t_r;    op_b = d_r;     end
      endcase
    end
    a_mag = op_a[OP_W-1] ? -op_a : op_a;
    b_mag = op_b[OP_W-1] ? -op_b : op_b;
  end

  assign prod    = mneg_r ? -$signed(acc_r) : $signed(acc_r);
  assign nn_new  = t_r - $signed(prod[OP_W-1:0]);
  assign num_new = s_r + prod;
  assign num_mag = num_new[PW-1] ? -num_new : num_new;
  assign den_mag = den_r[PW-1] ? -den_r : den_r;

  assign ge    = ({{QB{1'b0}}, rem_r} >= dd_r);
  assign q_fin = {q_r[QB-2:0], ge};
  always_comb begin
    if (dchk_r) begin
      div_x = dneg_r ? $signed({1'b1, {(X_W-1){1'b0}}}) : $signed({1'b0, {(X_W-1){1'b1}}});
    end else begin
      div_x = dneg_r ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
    end
  end

  always_comb begin
    lb  = xr_r[0];
    lt  = xr_r[1];
    rb  = xr_r[2];
    rt  = xr_r[3];
    llo = (lb < lt) ? lb : lt;
    lhi = (lb < lt) ? lt : lb;
    rhi = (rb > rt) ? rb : rt;
    rlo = (rb > rt) ? rt : rb;
    wv  = $signed({{(XC_W - REG_W){1'b0}}, stw_r});
    left_in  = (llo > 0) && (lhi > 0) && (XC_W'(llo) < wv) && (XC_W'(lhi) < wv);
    right_in = (rhi > 0) && (rlo > 0) && (XC_W'(rhi) < wv) && (XC_W'(rlo) < wv);
    csum   = '0;
    center = prev_r;
    ccase  = CASE_HELD;
    if (left_in && right_in) begin
      csum  = XC_W'(rhi) + XC_W'(llo);
      ccase = CASE_BOTH;
    end else if (((llo < 0) || (lhi < 0)) && right_in) begin
      csum  = XC_W'(rhi) + (wv >>> 1);
      ccase = CASE_RIGHT;
    end else if (((rhi < 0) || (rlo < 0)) && left_in) begin
      csum  = XC_W'(llo) + (wv >>> 1);
      ccase = CASE_LEFT;
    end
    if (ccase != CASE_HELD) begin
      center = csum[REG_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r     <= IMAGE_WIDTH_RST;
      bot_r       <= BOTTOM_ROW_RST;
      top_r       <= TOP_ROW_RST;
      stw_r       <= STEER_WIDTH_RST;
      for (int i = 0; i < 2; i++) begin
        cnt_r[i] <= '0;
        sx_r[i]  <= '0;
        sy_r[i]  <= '0;
        sxx_r[i] <= '0;
        sxy_r[i] <= '0;
      end
      state_r     <= ST_IDLE;
      step_r      <= '0;
      mbusy_r     <= 1'b0;
      lane_r      <= 1'b0;
      row_r       <= 1'b0;
      has_seg_r   <= 1'b0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH: img_w_r <= cfg_data;
          CFG_BOTTOM_ROW:  bot_r   <= cfg_data;
          CFG_TOP_ROW:     top_r   <= cfg_data;
          CFG_STEER_WIDTH: stw_r   <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      // start a product, run it a bit per cycle
      if ((state_r == ST_SEG || state_r == ST_FIT) && !mbusy_r) begin
        mbusy_r <= 1'b1;
        ma_r    <= {{(PW - OP_W){1'b0}}, a_mag};
        mb_r    <= b_mag;
        acc_r   <= '0;
        mneg_r  <= op_a[OP_W-1] ^ op_b[OP_W-1];
        mcnt_r  <= op_len;
      end else if (mbusy_r && mcnt_r != '0) begin
        if (mb_r[0]) begin
          acc_r <= acc_r + ma_r;
        end
        ma_r   <= ma_r << 1;
        mb_r   <= mb_r >> 1;
        mcnt_r <= mcnt_r - 1'b1;
      end

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            has_seg_r <= has_seg_r | in_tuser;
            last_r    <= in_tlast;
            x1_r      <= in_x1;
            y1_r      <= in_y1;
            x2_r      <= in_x2;
            y2_r      <= in_y2;
            side_r    <= go_right;
            step_r    <= '0;
            lane_r    <= 1'b0;
            row_r     <= 1'b0;
            mbusy_r   <= 1'b0;
            if (add_seg) begin
              cnt_r[sel] <= cnt_plus2[CNT_W-1:0];
              sx_r[sel]  <= sx_r[sel] + SX_W'(in_x1) + SX_W'(in_x2);
              sy_r[sel]  <= sy_r[sel] + SX_W'(in_y1) + SX_W'(in_y2);
              state_r    <= ST_SEG;
            end else if (in_tlast && (has_seg_r || in_tuser)) begin
              state_r <= ST_FIT;
            end
          end
        end

        ST_SEG: begin
          if (mbusy_r && mcnt_r == '0) begin
            mbusy_r <= 1'b0;
            step_r  <= step_r + 1'b1;
            if (step_r == SS_X1X1 || step_r == SS_X2X2) begin
              sxx_r[sel] <= sxx_r[sel] + prod[SXX_W-1:0];
            end else begin
              sxy_r[sel] <= sxy_r[sel] + prod[SXX_W-1:0];
            end
            if (step_r == SS_X2Y2) begin
              step_r  <= '0;
              state_r <= last_r ? ST_FIT : ST_IDLE;
            end
          end
        end

        ST_FIT: begin
          if (mbusy_r && mcnt_r == '0) begin
            mbusy_r <= 1'b0;
            step_r  <= step_r + 1'b1;
            case (step_r)
              FS_NXX: t_r <= prod[OP_W-1:0];
              FS_SXX: d_r <= t_r - $signed(prod[OP_W-1:0]);
              FS_NXY: t_r <= prod[OP_W-1:0];
              FS_SXY: begin
                nn_r <= nn_new;
                // degenerate or empty lane: report as missing
                if (d_r == '0 || nn_new == '0) begin
                  xr_r[{lane_r, 1'b0}] <= $signed({{(X_W - REG_W){1'b0}}, bot_r})
                                          - X_W'(MISSING_OFFSET);
                  xr_r[{lane_r, 1'b1}] <= $signed({{(X_W - REG_W){1'b0}}, top_r})
                                          - X_W'(MISSING_OFFSET);
                  step_r <= FS_NXX;
                  if (lane_r) begin
                    state_r <= ST_CTR;
                  end else begin
                    lane_r <= 1'b1;
                  end
                end
              end
              FS_SN: s_r   <= prod;
              FS_NN: den_r <= prod;
              FS_NY: t_r   <= $signed(prod[OP_W-1:0]) - ext_sy;
              default: begin
                rem_r   <= num_mag;
                dd_r    <= {den_mag, {QB{1'b0}}};
                dneg_r  <= num_new[PW-1] ^ den_r[PW-1];
                dchk_r  <= 1'b1;
                dcnt_r  <= 4'(QB - 1);
                q_r     <= '0;
                state_r <= ST_DIV;
              end
            endcase
          end
        end

        ST_DIV: begin
          if (dchk_r && !ge) begin
            dchk_r <= 1'b0;
            dd_r   <= dd_r >> 1;
          end else begin
            if (!dchk_r) begin
              if (ge) begin
                rem_r <= rem_r - dd_r[PW-1:0];
              end
              q_r    <= q_fin;
              dd_r   <= dd_r >> 1;
              dcnt_r <= dcnt_r - 1'b1;
            end
            // finish on saturation or after the last quotient bit
            if (dchk_r || dcnt_r == '0) begin
              xr_r[{lane_r, row_r}] <= div_x;
              if (!row_r) begin
                row_r   <= 1'b1;
                step_r  <= FS_NY;
                state_r <= ST_FIT;
              end else begin
                row_r  <= 1'b0;
                step_r <= FS_NXX;
                if (lane_r) begin
                  state_r <= ST_CTR;
                end else begin
                  lane_r  <= 1'b1;
                  state_r <= ST_FIT;
                end
              end
            end
          end
        end

        ST_CTR: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {{(OUT_DATA_W - REG_W - 4 * X_W){1'b0}},
                            rlo, rhi, lhi, llo, center};
            out_user_r  <= ccase;
            prev_r      <= center;
            has_seg_r   <= 1'b0;
            for (int i = 0; i < 2; i++) begin
              cnt_r[i] <= '0;
              sx_r[i]  <= '0;
              sy_r[i]  <= '0;
              sxx_r[i] <= '0;
              sxy_r[i] <= '0;
            end
            lane_r  <= 1'b0;
            state_r <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/lsfc_checker.sv
// Port checker for the lane segment fit and center block, with its bind.
`include "assert_macros.svh"

module lsfc_checker import lsfc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [CASE_W-1:0]     out_tuser
);

  logic [REG_W-1:0]      center;
  logic signed [X_W-1:0] llo, lhi, rhi, rlo;
  logic signed [X_W:0]   both_sum;

  assign center   = out_tdata[REG_W-1:0];
  assign llo      = out_tdata[REG_W+X_W-1:REG_W];
  assign lhi      = out_tdata[REG_W+2*X_W-1:REG_W+X_W];
  assign rhi      = out_tdata[REG_W+3*X_W-1:REG_W+2*X_W];
  assign rlo      = out_tdata[REG_W+4*X_W-1:REG_W+3*X_W];
  assign both_sum = (X_W + 1)'(rhi) + (X_W + 1)'(llo);

  `CHK_ASSERT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready |=> out_tvalid))
  `CHK_HOLD(a_out_stable, clk, rst_n, out_tvalid, out_tready, {out_tdata, out_tuser})
  `CHK_ASSERT(a_both_center, clk, rst_n, (out_tvalid && out_tuser == CASE_BOTH |-> llo > 0 && rhi > 0 && center == both_sum[REG_W:1]))
  `CHK_ASSERT(a_right_only, clk, rst_n, (out_tvalid && out_tuser == CASE_RIGHT |-> (llo < 0 || lhi < 0) && rlo > 0))
  `CHK_ASSERT(a_left_only, clk, rst_n, (out_tvalid && out_tuser == CASE_LEFT |-> (rhi < 0 || rlo < 0) && llo > 0))

endmodule

bind lane_segment_fit_center_core lsfc_checker u_lsfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
